### design/flash_command_state_machine_assert.svh
// Assertion macros shared by the flash command interface modules.
// Needs a clock named clock and an active-high reset named reset in scope.
`ifndef FLASH_COMMAND_STATE_MACHINE_ASSERT_SVH
`define FLASH_COMMAND_STATE_MACHINE_ASSERT_SVH

// Check that cond_a in a cycle implies cond_b in the same cycle.
`define FCSM_ASSERT_IMPL(label, cond_a, cond_b) \
   label: assert property (@(posedge clock) disable iff (reset) (cond_a) |-> (cond_b)) \
      else $error("flash command interface check failed");

// Check that a condition never holds.
`define FCSM_ASSERT_NEVER(label, cond_a) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond_a)) \
      else $error("flash command interface check failed");

`endif

### design/fcsm_pkg.sv
// Shared types and constants of the flash command interface.
// No dependencies; imported by every module of the block but fcsm_ram.
package fcsm_pkg;

   localparam int ADDR_W     = 17;
   localparam int DATA_W     = 16;
   localparam int BUF_DEPTH  = 32;
   localparam int BUF_AW     = 5;
   localparam int BUF_CNT_W  = 6;
   localparam int QUEUE_DEPTH = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   // Command bytes (low byte of a write)
   localparam logic [7:0] CMD_PROG_A     = 8'h40;
   localparam logic [7:0] CMD_PROG_B     = 8'h10;
   localparam logic [7:0] CMD_BUF_PROG   = 8'hE8;
   localparam logic [7:0] CMD_STATUS     = 8'h70;
   localparam logic [7:0] CMD_ARRAY_A    = 8'h50;
   localparam logic [7:0] CMD_ARRAY_B    = 8'hFF;
   localparam logic [7:0] CMD_READ_ID    = 8'h90;
   localparam logic [7:0] CMD_ERASE      = 8'h20;
   localparam logic [7:0] CMD_CONFIRM    = 8'hD0;

   localparam logic [DATA_W-1:0] STATUS_READY = 16'h0080;
   localparam logic [DATA_W-1:0] ERASED_WORD  = 16'hFFFF;

   // Configuration register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] CSR_WORD_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAKER     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PART      = 2'd2;
   localparam logic [7:0] MAKER_RESET = 8'd137;
   localparam logic [7:0] PART_RESET  = 8'd160;

   typedef enum logic [2:0] {
      CLS_NONE   = 3'd0,
      CLS_PROG   = 3'd1,
      CLS_BUF    = 3'd2,
      CLS_STATUS = 3'd3,
      CLS_ARRAY  = 3'd4,
      CLS_ID     = 3'd5,
      CLS_ERASE  = 3'd6
   } cmd_cls_type;

   // One decoded access, handed from the front to the back
   typedef struct packed {
      logic              is_write;
      logic [DATA_W-1:0] write_data;
      logic [ADDR_W-1:0] where;
      logic [ADDR_W-1:0] base;
      cmd_cls_type       cls;
      logic              confirm;
   } access_type;

   typedef struct packed {
      logic       word_mode;
      logic [7:0] maker_code;
      logic [7:0] part_code;
   } cfg_type;

endpackage

### design/fcsm_ram.sv
// Generic simple dual-port RAM with registered read data.
// No dependencies.
module fcsm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word, read one word a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/fcsm_front.sv
// Front end: accepts bus accesses, reduces the address to a word offset and
// block base, decodes the command byte. Depends on fcsm_pkg.
module fcsm_front import fcsm_pkg::*; #(
   parameter int ARRAY_WORDS = 65536,
   parameter int BLOCK_WORDS = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              word_mode,
   input  logic              hold,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_is_write,
   input  logic [ADDR_W-1:0] req_address,
   input  logic [DATA_W-1:0] req_write_data,
   output logic              push_valid,
   output access_type        push_entry,
   input  logic              push_ready
);

   localparam int RECIP_W = 19;
   localparam int DIV_W   = 25;
   localparam int PROD_W  = ADDR_W + RECIP_W;
   localparam int QN_W    = ADDR_W + DIV_W;
   localparam int A_SH    = ADDR_W + $clog2(ARRAY_WORDS);
   localparam int B_SH    = ADDR_W + $clog2(BLOCK_WORDS);
   localparam logic [RECIP_W-1:0] A_RECIP = RECIP_W'((64'd1 << A_SH) / ARRAY_WORDS);
   localparam logic [RECIP_W-1:0] B_RECIP = RECIP_W'((64'd1 << B_SH) / BLOCK_WORDS);
   localparam logic [DIV_W-1:0]   A_DIV   = DIV_W'(ARRAY_WORDS);
   localparam logic [DIV_W-1:0]   B_DIV   = DIV_W'(BLOCK_WORDS);

   typedef enum logic [7:0] {
      F_IDLE = 8'b0000_0001,
      F_AMUL = 8'b0000_0010,
      F_AMOD = 8'b0000_0100,
      F_ARED = 8'b0000_1000,
      F_BMUL = 8'b0001_0000,
      F_BMOD = 8'b0010_0000,
      F_BRED = 8'b0100_0000,
      F_PUSH = 8'b1000_0000
   } fstate_type;

   fstate_type         fstate_ff, fstate_in;
   logic [ADDR_W-1:0]  x_ff, x_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [ADDR_W-1:0]  qn_ff, qn_in;
   access_type         ent_ff, ent_in;

   logic               use_a;
   logic [RECIP_W-1:0] recip;
   logic [DIV_W-1:0]   div;
   logic [ADDR_W-1:0]  quot;
   logic [QN_W-1:0]    qn_full;
   logic [ADDR_W-1:0]  rem_raw;
   logic [ADDR_W-1:0]  rem;

   function automatic cmd_cls_type classify(input logic [7:0] code);
      cmd_cls_type cls;
      cls = CLS_NONE;
      case (code)
         CMD_PROG_A, CMD_PROG_B:   cls = CLS_PROG;
         CMD_BUF_PROG:             cls = CLS_BUF;
         CMD_STATUS:               cls = CLS_STATUS;
         CMD_ARRAY_A, CMD_ARRAY_B: cls = CLS_ARRAY;
         CMD_READ_ID:              cls = CLS_ID;
         CMD_ERASE:                cls = CLS_ERASE;
         default:                  cls = CLS_NONE;
      endcase
      return cls;
   endfunction

   // Constant-divisor remainder: reciprocal multiply, back-multiply, one fixup
   assign use_a   = (fstate_ff == F_AMUL) || (fstate_ff == F_AMOD) || (fstate_ff == F_ARED);
   assign recip   = use_a ? A_RECIP : B_RECIP;
   assign div     = use_a ? A_DIV : B_DIV;
   assign quot    = use_a ? ADDR_W'(prod_ff >> A_SH) : ADDR_W'(prod_ff >> B_SH);
   assign qn_full = QN_W'(quot) * QN_W'(div);
   assign rem_raw = x_ff - qn_ff;
   assign rem     = (DIV_W'(rem_raw) >= div) ? rem_raw - ADDR_W'(div) : rem_raw;

   assign req_ready  = (fstate_ff == F_IDLE) && !hold;
   assign push_valid = (fstate_ff == F_PUSH);
   assign push_entry = ent_ff;

   // Sequence the address reduction
   always_comb begin
      fstate_in = fstate_ff;
      x_in      = x_ff;
      prod_in   = prod_ff;
      qn_in     = qn_ff;
      ent_in    = ent_ff;
      case (fstate_ff)
         F_IDLE: begin
            if (req_valid && req_ready) begin
               x_in = word_mode ? {1'b0, req_address[ADDR_W-1:1]} : req_address;
               ent_in.is_write   = req_is_write;
               ent_in.write_data = req_write_data;
               ent_in.cls        = classify(req_write_data[7:0]);
               ent_in.confirm    = (req_write_data[7:0] == CMD_CONFIRM);
               fstate_in = F_AMUL;
            end
         end
         F_AMUL: begin
            prod_in   = PROD_W'(x_ff) * PROD_W'(recip);
            fstate_in = F_AMOD;
         end
         F_AMOD: begin
            qn_in     = qn_full[ADDR_W-1:0];
            fstate_in = F_ARED;
         end
         F_ARED: begin
            x_in         = rem;
            ent_in.where = rem;
            fstate_in    = F_BMUL;
         end
         F_BMUL: begin
            prod_in   = PROD_W'(x_ff) * PROD_W'(recip);
            fstate_in = F_BMOD;
         end
         F_BMOD: begin
            qn_in     = qn_full[ADDR_W-1:0];
            fstate_in = F_BRED;
         end
         F_BRED: begin
            ent_in.base = ent_ff.where - rem;
            fstate_in   = F_PUSH;
         end
         F_PUSH: begin
            if (push_ready) begin
               fstate_in = F_IDLE;
            end
         end
         default: fstate_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fstate_ff <= F_IDLE;
      end else begin
         fstate_ff <= fstate_in;
      end
      x_ff    <= x_in;
      prod_ff <= prod_in;
      qn_ff   <= qn_in;
      ent_ff  <= ent_in;
   end

endmodule

### design/fcsm_queue.sv
// Short queue of decoded accesses between the front and the back.
// Depends on fcsm_pkg.
module fcsm_queue import fcsm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push_valid,
   output logic       push_ready,
   input  access_type push_entry,
   output logic       pop_valid,
   input  logic       pop_ready,
   output access_type pop_entry
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   access_type       slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### design/fcsm_back.sv
// Back end: command state machine, write buffer, flash array and result
// register. Depends on fcsm_pkg, fcsm_ram and flash_command_state_machine_assert.svh.
`include "flash_command_state_machine_assert.svh"
module fcsm_back import fcsm_pkg::*; #(
   parameter int ARRAY_WORDS = 65536,
   parameter int BLOCK_WORDS = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              q_valid,
   input  access_type        q_entry,
   output logic              q_pop,
   output logic              clear_busy,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [DATA_W-1:0] rsp_read_data
);

   localparam int WA      = $clog2(ARRAY_WORDS);
   localparam int MAX_SW  = (ARRAY_WORDS > BLOCK_WORDS) ? ARRAY_WORDS : BLOCK_WORDS;
   localparam int SWEEP_W = $clog2(MAX_SW + 1);
   localparam logic [WA-1:0] LAST_ADDR = WA'(ARRAY_WORDS - 1);

   typedef enum logic [9:0] {
      ST_READ_ARRAY  = 10'b00_0000_0001,
      ST_READ_ID     = 10'b00_0000_0010,
      ST_READ_STATUS = 10'b00_0000_0100,
      ST_BUF_COUNT   = 10'b00_0000_1000,
      ST_BUF_DATA    = 10'b00_0001_0000,
      ST_BUF_CONFIRM = 10'b00_0010_0000,
      ST_PROG        = 10'b00_0100_0000,
      ST_PROG_DONE   = 10'b00_1000_0000,
      ST_ERASE       = 10'b01_0000_0000,
      ST_ERASE_DONE  = 10'b10_0000_0000
   } cmd_state_type;

   typedef enum logic [4:0] {
      B_CLEAR  = 5'b00001,
      B_IDLE   = 5'b00010,
      B_RDWAIT = 5'b00100,
      B_COMMIT = 5'b01000,
      B_ERASE  = 5'b10000
   } bstate_type;

   bstate_type          bstate_ff, bstate_in;
   cmd_state_type       cmd_ff, cmd_in;
   logic [ADDR_W-1:0]   buf_start_ff, buf_start_in;
   logic [BUF_CNT_W-1:0] buf_count_ff, buf_count_in;
   logic [BUF_CNT_W-1:0] buf_rem_ff, buf_rem_in;
   logic [WA-1:0]       sweep_addr_ff, sweep_addr_in;
   logic [SWEEP_W-1:0]  sweep_left_ff, sweep_left_in;
   logic [BUF_CNT_W-1:0] cnt_ff, cnt_in;
   logic                pend_ff, pend_in;
   logic [WA-1:0]       wr_addr_ff, wr_addr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   logic                arr_we;
   logic [WA-1:0]       arr_waddr;
   logic [DATA_W-1:0]   arr_wdata;
   logic [WA-1:0]       arr_raddr;
   logic [DATA_W-1:0]   arr_rdata;
   logic                buf_we;
   logic [BUF_AW-1:0]   buf_waddr;
   logic [BUF_AW-1:0]   buf_raddr;
   logic [DATA_W-1:0]   buf_rdata;

   logic                out_free;
   logic                take_cmd;
   logic [WA-1:0]       sweep_next;
   logic [ADDR_W-1:0]   buf_diff;
   logic                in_range;
   logic [BUF_CNT_W-1:0] rem_dec;

   // Byte-wide chip keeps and shows only the low byte
   function automatic logic [DATA_W-1:0] cell_keep(input logic wm, input logic [DATA_W-1:0] v);
      return wm ? v : {8'h00, v[7:0]};
   endfunction

   function automatic cmd_state_type cmd_next(input cmd_cls_type cls, input cmd_state_type cur);
      cmd_state_type nxt;
      nxt = cur;
      case (cls)
         CLS_PROG:   nxt = ST_PROG;
         CLS_BUF:    nxt = ST_BUF_COUNT;
         CLS_STATUS: nxt = ST_READ_STATUS;
         CLS_ARRAY:  nxt = ST_READ_ARRAY;
         CLS_ID:     nxt = ST_READ_ID;
         CLS_ERASE:  nxt = ST_ERASE;
         default:    nxt = cur;
      endcase
      return nxt;
   endfunction

   fcsm_ram #(.WIDTH(DATA_W), .DEPTH(ARRAY_WORDS)) u_array (
      .clock   (clock),
      .wr_en   (arr_we),
      .wr_addr (arr_waddr),
      .wr_data (arr_wdata),
      .rd_addr (arr_raddr),
      .rd_data (arr_rdata)
   );

   fcsm_ram #(.WIDTH(DATA_W), .DEPTH(BUF_DEPTH)) u_wbuf (
      .clock   (clock),
      .wr_en   (buf_we),
      .wr_addr (buf_waddr),
      .wr_data (q_entry.write_data),
      .rd_addr (buf_raddr),
      .rd_data (buf_rdata)
   );

   assign out_free      = !rsp_valid_ff || rsp_ready;
   assign clear_busy    = (bstate_ff == B_CLEAR);
   assign sweep_next    = (sweep_addr_ff == LAST_ADDR) ? '0 : sweep_addr_ff + 1'b1;
   assign buf_diff      = q_entry.where - buf_start_ff;
   assign in_range      = (q_entry.where >= buf_start_ff) &&
                          (buf_diff < ADDR_W'(buf_count_ff));
   assign rem_dec       = (buf_rem_ff != '0) ? buf_rem_ff - 1'b1 : buf_rem_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

   // Execute one access per transfer from the queue, or run a sweep
   always_comb begin
      bstate_in     = bstate_ff;
      cmd_in        = cmd_ff;
      buf_start_in  = buf_start_ff;
      buf_count_in  = buf_count_ff;
      buf_rem_in    = buf_rem_ff;
      sweep_addr_in = sweep_addr_ff;
      sweep_left_in = sweep_left_ff;
      cnt_in        = cnt_ff;
      pend_in       = pend_ff;
      wr_addr_in    = wr_addr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      arr_we        = 1'b0;
      arr_waddr     = sweep_addr_ff;
      arr_wdata     = ERASED_WORD;
      arr_raddr     = WA'(q_entry.where);
      buf_we        = 1'b0;
      buf_waddr     = buf_diff[BUF_AW-1:0];
      buf_raddr     = cnt_ff[BUF_AW-1:0];
      q_pop         = 1'b0;
      take_cmd      = 1'b0;
      case (bstate_ff)
         B_CLEAR, B_ERASE: begin
            arr_we        = 1'b1;
            arr_wdata     = (bstate_ff == B_CLEAR) ? ERASED_WORD
                                                   : cell_keep(cfg.word_mode, ERASED_WORD);
            sweep_addr_in = sweep_next;
            sweep_left_in = sweep_left_ff - 1'b1;
            if (sweep_left_ff == SWEEP_W'(1)) begin
               bstate_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (q_valid && out_free) begin
               q_pop        = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               case (cmd_ff)
                  ST_READ_ID: begin
                     if (q_entry.is_write) begin
                        take_cmd = 1'b1;
                     end else if (q_entry.where == '0) begin
                        rsp_data_in = {8'h00, cfg.maker_code};
                     end else if (q_entry.where == ADDR_W'(1)) begin
                        rsp_data_in = {8'h00, cfg.part_code};
                     end
                  end
                  ST_READ_STATUS: begin
                     if (!q_entry.is_write) begin
                        rsp_data_in = STATUS_READY;
                     end
                     cmd_in = ST_READ_ARRAY;
                  end
                  ST_BUF_COUNT: begin
                     if (q_entry.is_write) begin
                        buf_count_in = BUF_CNT_W'(q_entry.write_data[BUF_AW-1:0])
                                       + BUF_CNT_W'(1);
                        buf_rem_in   = buf_count_in;
                        cmd_in       = ST_BUF_DATA;
                     end else begin
                        rsp_data_in = STATUS_READY;
                     end
                  end
                  ST_BUF_DATA: begin
                     if (q_entry.is_write) begin
                        if (in_range) begin
                           buf_we     = 1'b1;
                           buf_rem_in = rem_dec;
                           if (rem_dec == '0) begin
                              cmd_in = ST_BUF_CONFIRM;
                           end
                        end
                     end else begin
                        rsp_data_in = STATUS_READY;
                     end
                  end
                  ST_BUF_CONFIRM: begin
                     if (q_entry.is_write) begin
                        if (q_entry.confirm) begin
                           cnt_in        = '0;
                           pend_in       = 1'b0;
                           sweep_addr_in = WA'(buf_start_ff);
                           bstate_in     = B_COMMIT;
                        end
                        cmd_in = ST_READ_ARRAY;
                     end else begin
                        rsp_data_in = STATUS_READY;
                     end
                  end
                  ST_PROG: begin
                     if (q_entry.is_write) begin
                        arr_we    = 1'b1;
                        arr_waddr = WA'(q_entry.where);
                        arr_wdata = cell_keep(cfg.word_mode, q_entry.write_data);
                        cmd_in    = ST_PROG_DONE;
                     end
                  end
                  ST_PROG_DONE, ST_ERASE_DONE: begin
                     if (q_entry.is_write) begin
                        take_cmd = 1'b1;
                     end else begin
                        rsp_data_in = STATUS_READY;
                     end
                  end
                  ST_ERASE: begin
                     if (q_entry.is_write) begin
                        if (q_entry.confirm) begin
                           sweep_addr_in = WA'(q_entry.base);
                           sweep_left_in = SWEEP_W'(BLOCK_WORDS);
                           bstate_in     = B_ERASE;
                           cmd_in        = ST_ERASE_DONE;
                        end
                     end else begin
                        rsp_data_in = STATUS_READY;
                     end
                  end
                  default: begin
                     cmd_in = ST_READ_ARRAY;
                     if (q_entry.is_write) begin
                        take_cmd = 1'b1;
                     end else begin
                        rsp_valid_in = 1'b0;
                        bstate_in    = B_RDWAIT;
                     end
                  end
               endcase
               // Apply a command byte
               if (take_cmd) begin
                  cmd_in = cmd_next(q_entry.cls, cmd_in);
                  if (q_entry.cls == CLS_BUF) begin
                     buf_start_in = q_entry.where;
                     buf_count_in = '0;
                     buf_rem_in   = '0;
                  end
               end
            end
         end
         B_RDWAIT: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = cell_keep(cfg.word_mode, arr_rdata);
            bstate_in    = B_IDLE;
         end
         B_COMMIT: begin
            // Read a buffer word, write it to the array in the following cycle
            if (cnt_ff != buf_count_ff) begin
               cnt_in        = cnt_ff + 1'b1;
               wr_addr_in    = sweep_addr_ff;
               sweep_addr_in = sweep_next;
               pend_in       = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               arr_we    = 1'b1;
               arr_waddr = wr_addr_ff;
               arr_wdata = cell_keep(cfg.word_mode, buf_rdata);
            end
            if ((cnt_ff == buf_count_ff) && !pend_ff) begin
               bstate_in = B_IDLE;
            end
         end
         default: bstate_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bstate_ff     <= B_CLEAR;
         cmd_ff        <= ST_READ_ARRAY;
         buf_start_ff  <= '0;
         buf_count_ff  <= '0;
         buf_rem_ff    <= '0;
         sweep_addr_ff <= '0;
         sweep_left_ff <= SWEEP_W'(ARRAY_WORDS);
         cnt_ff        <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         bstate_ff     <= bstate_in;
         cmd_ff        <= cmd_in;
         buf_start_ff  <= buf_start_in;
         buf_count_ff  <= buf_count_in;
         buf_rem_ff    <= buf_rem_in;
         sweep_addr_ff <= sweep_addr_in;
         sweep_left_ff <= sweep_left_in;
         cnt_ff        <= cnt_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      wr_addr_ff  <= wr_addr_in;
      rsp_data_ff <= rsp_data_in;
   end

   `FCSM_ASSERT_IMPL(a_pop_needs_free_output, q_pop, !rsp_valid_ff || rsp_ready)
   `FCSM_ASSERT_IMPL(a_rdwait_output_empty, bstate_ff == B_RDWAIT, !rsp_valid_ff)
   `FCSM_ASSERT_NEVER(a_remaining_within_count, buf_rem_ff > buf_count_ff)
   `FCSM_ASSERT_IMPL(a_commit_count_bound, bstate_ff == B_COMMIT, cnt_ff <= buf_count_ff)

endmodule

### design/flash_command_state_machine.sv
// Top level of the flash command interface: configuration registers and the
// front, queue and back. Depends on fcsm_pkg, fcsm_front, fcsm_queue, fcsm_back.
//
// One bus access (read or write) is taken per req_ transfer and gives exactly
// one rsp_ transfer. The front reduces each address with a short multiply
// sequence (F_AMUL to F_BRED) and takes no new access until it has pushed
// the last one; a 2-entry queue lets the front keep taking accesses while
// the back or the result register is stalled. Array reads pass through
// B_RDWAIT in the back for the registered array read. A confirmed block erase
// holds the back while it writes the BLOCK_WORDS words of the block (one array
// word written per cycle) and a buffer commit while it copies the buffer
// words to the array. After reset the back sweeps the whole array to the
// erased value, during which req_ready stays low; csr_ writes are taken at
// any time but must only be issued while no access is in flight.
module flash_command_state_machine import fcsm_pkg::*; #(
   parameter int ARRAY_WORDS = 65536,
   parameter int BLOCK_WORDS = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_is_write,
   input  logic [ADDR_W-1:0]     req_address,
   input  logic [DATA_W-1:0]     req_write_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [DATA_W-1:0]     rsp_read_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   cfg_type    cfg_ff, cfg_in;
   logic       push_valid;
   logic       push_ready;
   access_type push_entry;
   logic       q_valid;
   logic       q_pop;
   access_type q_entry;
   logic       clear_busy;

   // Write configuration registers; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_WORD_MODE: cfg_in.word_mode  = csr_wr_data[0];
            CSR_MAKER:     cfg_in.maker_code = csr_wr_data;
            CSR_PART:      cfg_in.part_code  = csr_wr_data;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.word_mode  <= 1'b0;
         cfg_ff.maker_code <= MAKER_RESET;
         cfg_ff.part_code  <= PART_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fcsm_front #(.ARRAY_WORDS(ARRAY_WORDS), .BLOCK_WORDS(BLOCK_WORDS)) u_front (
      .clock          (clock),
      .reset          (reset),
      .word_mode      (cfg_ff.word_mode),
      .hold           (clear_busy),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_is_write   (req_is_write),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .push_valid     (push_valid),
      .push_entry     (push_entry),
      .push_ready     (push_ready)
   );

   fcsm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (q_valid),
      .pop_ready  (q_pop),
      .pop_entry  (q_entry)
   );

   fcsm_back #(.ARRAY_WORDS(ARRAY_WORDS), .BLOCK_WORDS(BLOCK_WORDS)) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .q_valid       (q_valid),
      .q_entry       (q_entry),
      .q_pop         (q_pop),
      .clear_busy    (clear_busy),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_read_data (rsp_read_data)
   );

endmodule
